FILE: design/bsta_pkg.sv
// Shared types and constants for the beacon strength table with aging.
package bsta_pkg;

	localparam int NUM_ENTRIES = 8;
	localparam int IDX_W       = 3;
	localparam int ADDR_W      = 48;
	localparam int TIME_W      = 48;
	localparam int STR_W       = 8;
	localparam int PADDR_W     = 6;
	localparam int PDATA_W     = 64;

	localparam logic [31:0] TTL_LIMIT_MS = 32'd1000;

	localparam logic FUNC_REPORT = 1'b0;
	localparam logic FUNC_READ   = 1'b1;

	localparam logic [ADDR_W-1:0] ID_RESET [NUM_ENTRIES] = '{
		48'h000780AD0946, 48'h000780AD094B, 48'h000780AD094F, 48'h000780AD094E,
		48'h000780AD094A, 48'h000780AD0955, 48'h000780AD0992, 48'h000780AD0933
	};

	typedef struct packed {
		logic                   valid;
		logic                   func;
		logic [ADDR_W-1:0]      addr;
		logic [STR_W-1:0]       strength;
		logic [TIME_W-1:0]      now;
		logic [IDX_W-1:0]       idx;
		logic                   hit;
		logic [IDX_W-1:0]       hit_index;
		logic [STR_W-1:0]       es;
		logic [TIME_W-1:0]      els;
		logic [NUM_ENTRIES-1:0] mask;
	} tok_t;

endpackage

FILE: design/bsta_cell.sv
// One table cell: holds an entry, matches, ages and forwards the request token.
module bsta_cell #(
	parameter int unsigned INDEX        = 0,
	parameter logic [31:0] TTL_LIMIT_MS = bsta_pkg::TTL_LIMIT_MS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr,
	input  logic [bsta_pkg::ADDR_W-1:0]   wdata,
	output logic [bsta_pkg::ADDR_W-1:0]   id,
	input  bsta_pkg::tok_t                tok_in,
	output bsta_pkg::tok_t                tok_out
);

	logic [bsta_pkg::ADDR_W-1:0] id_q;
	logic [bsta_pkg::STR_W-1:0]  strength_q;
	logic [bsta_pkg::TIME_W-1:0] last_seen_q;
	bsta_pkg::tok_t              tok_q;

	logic [bsta_pkg::STR_W-1:0]  strength_d;
	logic [bsta_pkg::TIME_W-1:0] last_seen_d;
	logic [bsta_pkg::TIME_W-1:0] age;
	logic                        report;
	logic                        take;
	bsta_pkg::tok_t              tok_d;

	assign report = tok_in.valid && (tok_in.func == bsta_pkg::FUNC_REPORT)
		&& tok_in.strength[bsta_pkg::STR_W-1];
	assign take   = report && !tok_in.hit && (id_q == tok_in.addr);
	assign age    = tok_in.now - last_seen_q;

	always_comb begin
		strength_d  = strength_q;
		last_seen_d = last_seen_q;
		tok_d       = tok_in;
		if (take) begin
			strength_d      = tok_in.strength;
			last_seen_d     = tok_in.now;
			tok_d.hit       = 1'b1;
			tok_d.hit_index = bsta_pkg::IDX_W'(INDEX);
			tok_d.es        = tok_in.strength;
			tok_d.els       = tok_in.now;
		end else if (report && (age >= {16'd0, TTL_LIMIT_MS})) begin
			strength_d  = '0;
			last_seen_d = '0;
		end
		if (tok_in.valid && (tok_in.func == bsta_pkg::FUNC_READ)
			&& (tok_in.idx == bsta_pkg::IDX_W'(INDEX))) begin
			tok_d.es  = strength_q;
			tok_d.els = last_seen_q;
		end
		tok_d.mask[INDEX] = (strength_d != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_q        <= bsta_pkg::ID_RESET[INDEX];
			strength_q  <= '0;
			last_seen_q <= '0;
			tok_q       <= '0;
		end else begin
			if (wr) begin
				id_q <= wdata;
			end
			strength_q  <= strength_d;
			last_seen_q <= last_seen_d;
			tok_q       <= tok_d;
		end
	end

	assign id      = id_q;
	assign tok_out = tok_q;

endmodule

FILE: design/beacon_strength_table_with_aging_core.sv
// Top level of the beacon strength table with aging: request port, cell chain, result register.
// A request passes through a chain of eight cells, one cell per clock, and each cell matches,
// updates and ages its own entry as a report with the strength sign bit set goes by; a read
// picks up the selected entry. The result is captured in the output register after the last
// cell; the next request is taken once that result has been delivered. Writes to the beacon
// id registers go through the APB port at byte address 8*i and may be issued at any time the
// block is idle.
module beacon_strength_table_with_aging_core #(
	parameter logic [31:0] TTL_LIMIT_MS = bsta_pkg::TTL_LIMIT_MS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bsta_pkg::PADDR_W-1:0]     paddr,
	input  logic [bsta_pkg::PDATA_W-1:0]     pwdata,
	output logic [bsta_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             func,
	input  logic [bsta_pkg::ADDR_W-1:0]      beacon_address,
	input  logic signed [bsta_pkg::STR_W-1:0] signal_strength,
	input  logic [bsta_pkg::TIME_W-1:0]      now_ms,
	input  logic [bsta_pkg::IDX_W-1:0]       entry_index,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             matched,
	output logic [bsta_pkg::IDX_W-1:0]       match_index,
	output logic signed [bsta_pkg::STR_W-1:0] entry_strength,
	output logic [bsta_pkg::TIME_W-1:0]      entry_last_seen,
	output logic [bsta_pkg::NUM_ENTRIES-1:0] visible_mask
);

	localparam int N = bsta_pkg::NUM_ENTRIES;

	bsta_pkg::tok_t              chain [N+1];
	logic [bsta_pkg::ADDR_W-1:0] ids [N];
	logic                        wr_en;
	logic [bsta_pkg::IDX_W-1:0]  reg_sel;
	logic                        in_acc;
	logic                        out_acc;
	logic                        busy_q;
	logic                        out_valid_q;
	bsta_pkg::tok_t              res_q;

	assign pready  = 1'b1;
	assign reg_sel = paddr[bsta_pkg::PADDR_W-1:bsta_pkg::PADDR_W-bsta_pkg::IDX_W];
	assign wr_en   = psel && penable && pwrite;
	assign prdata  = {{(bsta_pkg::PDATA_W-bsta_pkg::ADDR_W){1'b0}}, ids[reg_sel]};

	assign in_stall = busy_q;
	assign in_acc   = in_valid && !busy_q;
	assign out_acc  = out_valid_q && !out_stall;

	always_comb begin
		chain[0]           = '0;
		chain[0].valid     = in_acc;
		chain[0].func      = func;
		chain[0].addr      = beacon_address;
		chain[0].strength  = $unsigned(signal_strength);
		chain[0].now       = now_ms;
		chain[0].idx       = entry_index;
	end

	for (genvar g = 0; g < N; g++) begin : g_cell
		bsta_cell #(
			.INDEX        (g),
			.TTL_LIMIT_MS (TTL_LIMIT_MS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.wr      (wr_en && (reg_sel == bsta_pkg::IDX_W'(g))),
			.wdata   (pwdata[bsta_pkg::ADDR_W-1:0]),
			.id      (ids[g]),
			.tok_in  (chain[g]),
			.tok_out (chain[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (in_acc) begin
				busy_q <= 1'b1;
			end else if (out_acc) begin
				busy_q <= 1'b0;
			end
			if (chain[N].valid) begin
				out_valid_q <= 1'b1;
				res_q       <= chain[N];
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign matched         = res_q.hit;
	assign match_index     = res_q.hit_index;
	assign entry_strength  = $signed(res_q.es);
	assign entry_last_seen = res_q.els;
	assign visible_mask    = res_q.mask;

	logic [N:0] chain_valid;
	always_comb begin
		for (int k = 0; k <= N; k++) begin
			chain_valid[k] = chain[k].valid;
		end
	end

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({chain_valid, out_valid_q}))
		else $error("more than one request in flight");

	a_out_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> busy_q)
		else $error("result pending while block idle");

	a_chain_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		chain[N].valid |=> out_valid_q)
		else $error("chain output not captured");

	a_hit_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.hit) |-> res_q.mask[res_q.hit_index])
		else $error("matched entry not visible");

endmodule

FILE: test/beacon_strength_table_with_aging_core_test.sv
// Self-checking testbench for the beacon strength table with aging core.
module beacon_strength_table_with_aging_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [bsta_pkg::TIME_W-1:0] TIME_MAX = {bsta_pkg::TIME_W{1'b1}};
	localparam logic [bsta_pkg::ADDR_W-1:0] ADDR_MAX = {bsta_pkg::ADDR_W{1'b1}};
	localparam int PHASE_ITEMS = 330;
	localparam int SQUEEZE_AT = 400;
	localparam int SQUEEZE_CYCLES = 300;

	typedef struct packed {
		logic                        func;
		logic [bsta_pkg::ADDR_W-1:0] addr;
		logic [bsta_pkg::STR_W-1:0]  strength;
		logic [bsta_pkg::TIME_W-1:0] now;
		logic [bsta_pkg::IDX_W-1:0]  idx;
	} beacon_req_t;

	typedef struct packed {
		logic                             matched;
		logic [bsta_pkg::IDX_W-1:0]       index;
		logic [bsta_pkg::STR_W-1:0]       strength;
		logic [bsta_pkg::TIME_W-1:0]      last_seen;
		logic [bsta_pkg::NUM_ENTRIES-1:0] mask;
	} sighting_t;

	typedef struct {
		beacon_req_t req;
		bit          typed;
		sighting_t   want;
	} script_row_t;

	logic                             clk = 1'b0;
	logic                             arst_n;
	logic                             psel;
	logic                             penable;
	logic                             pwrite;
	logic [bsta_pkg::PADDR_W-1:0]     paddr;
	logic [bsta_pkg::PDATA_W-1:0]     pwdata;
	logic [bsta_pkg::PDATA_W-1:0]     prdata;
	logic                             pready;
	logic                             in_valid;
	logic                             in_stall;
	logic                             func;
	logic [bsta_pkg::ADDR_W-1:0]      beacon_address;
	logic signed [bsta_pkg::STR_W-1:0] signal_strength;
	logic [bsta_pkg::TIME_W-1:0]      now_ms;
	logic [bsta_pkg::IDX_W-1:0]       entry_index;
	logic                             out_valid;
	logic                             out_stall;
	logic                             matched;
	logic [bsta_pkg::IDX_W-1:0]       match_index;
	logic signed [bsta_pkg::STR_W-1:0] entry_strength;
	logic [bsta_pkg::TIME_W-1:0]      entry_last_seen;
	logic [bsta_pkg::NUM_ENTRIES-1:0] visible_mask;

	logic [bsta_pkg::ADDR_W-1:0] id_mirror [bsta_pkg::NUM_ENTRIES];
	logic [bsta_pkg::STR_W-1:0]  strength_mirror [bsta_pkg::NUM_ENTRIES];
	logic [bsta_pkg::TIME_W-1:0] seen_mirror [bsta_pkg::NUM_ENTRIES];
	logic [bsta_pkg::TIME_W-1:0] clock_ms;

	sighting_t   pending_sightings [$];
	script_row_t script [$];
	int          mismatches = 0;
	int          accepted_total = 0;
	bit          calm = 1'b0;
	bit          squeeze_done = 1'b0;

	beacon_strength_table_with_aging_core uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .func(func),
		.beacon_address(beacon_address), .signal_strength(signal_strength),
		.now_ms(now_ms), .entry_index(entry_index),
		.out_valid(out_valid), .out_stall(out_stall), .matched(matched),
		.match_index(match_index), .entry_strength(entry_strength),
		.entry_last_seen(entry_last_seen), .visible_mask(visible_mask)
	);

	always #5 clk = ~clk;

	function automatic logic [47:0] rand48();
		return 48'({$urandom, $urandom});
	endfunction

	function automatic sighting_t table_outcome(beacon_req_t r);
		sighting_t res;
		logic hit;
		logic [bsta_pkg::IDX_W-1:0] hit_slot;
		logic [bsta_pkg::TIME_W-1:0] age;
		res = '0;
		hit = 1'b0;
		hit_slot = '0;
		if (r.func == bsta_pkg::FUNC_READ) begin
			res.strength = strength_mirror[r.idx];
			res.last_seen = seen_mirror[r.idx];
		end else if (r.strength[bsta_pkg::STR_W-1]) begin
			for (int i = 0; i < bsta_pkg::NUM_ENTRIES; i++) begin
				if (!hit && id_mirror[i] == r.addr) begin
					hit = 1'b1;
					hit_slot = bsta_pkg::IDX_W'(i);
				end
			end
			if (hit) begin
				strength_mirror[hit_slot] = r.strength;
				seen_mirror[hit_slot] = r.now;
			end
			for (int i = 0; i < bsta_pkg::NUM_ENTRIES; i++) begin
				age = r.now - seen_mirror[i];
				if (age >= bsta_pkg::TIME_W'(bsta_pkg::TTL_LIMIT_MS)) begin
					strength_mirror[i] = '0;
					seen_mirror[i] = '0;
				end
			end
			if (hit) begin
				res.matched = 1'b1;
				res.index = hit_slot;
				res.strength = strength_mirror[hit_slot];
				res.last_seen = seen_mirror[hit_slot];
			end
		end
		for (int i = 0; i < bsta_pkg::NUM_ENTRIES; i++)
			res.mask[i] = (strength_mirror[i] != '0);
		return res;
	endfunction

	function automatic beacon_req_t next_request();
		beacon_req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 3)
			clock_ms = rand48();
		else
			clock_ms = clock_ms + bsta_pkg::TIME_W'($urandom_range(0, 600));
		r.func = bsta_pkg::FUNC_REPORT;
		r.addr = rand48();
		r.strength = bsta_pkg::STR_W'($urandom_range(128, 255));
		r.now = clock_ms;
		r.idx = bsta_pkg::IDX_W'($urandom);
		if (pick < 62) begin
			r.addr = id_mirror[$urandom_range(0, bsta_pkg::NUM_ENTRIES-1)];
		end else if (pick >= 72 && pick < 80) begin
			r.strength = bsta_pkg::STR_W'($urandom_range(0, 127));
			r.now = rand48();
			if (pick < 76)
				r.addr = id_mirror[$urandom_range(0, bsta_pkg::NUM_ENTRIES-1)];
		end else if (pick >= 80) begin
			r.func = bsta_pkg::FUNC_READ;
			r.strength = bsta_pkg::STR_W'($urandom);
			r.now = rand48();
		end
		return r;
	endfunction

	task automatic add_row(input logic f, input logic [bsta_pkg::ADDR_W-1:0] a,
			input logic [bsta_pkg::STR_W-1:0] s, input logic [bsta_pkg::TIME_W-1:0] t,
			input logic [bsta_pkg::IDX_W-1:0] i, input bit typed,
			input logic m, input logic [bsta_pkg::IDX_W-1:0] mi,
			input logic [bsta_pkg::STR_W-1:0] es, input logic [bsta_pkg::TIME_W-1:0] els,
			input logic [bsta_pkg::NUM_ENTRIES-1:0] mask);
		script_row_t row;
		row.req = {f, a, s, t, i};
		row.typed = typed;
		row.want = {m, mi, es, els, mask};
		script.push_back(row);
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch on %s at %0t: got %h, expected %h", what, $realtime, got, want);
		mismatches++;
	endtask

	// Called at a falling edge; returns at a falling edge after acceptance.
	task automatic send_request(input beacon_req_t r, input bit typed, input sighting_t want);
		sighting_t predicted;
		in_valid <= 1'b1;
		func <= r.func;
		beacon_address <= r.addr;
		signal_strength <= r.strength;
		now_ms <= r.now;
		entry_index <= r.idx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = table_outcome(r);
		pending_sightings.push_back(typed ? want : predicted);
		accepted_total++;
		@(negedge clk);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10))
				@(negedge clk);
		end
	endtask

	// Leaves the bus in the access phase; caller drops psel after the last write.
	task automatic write_beacon_id(input int slot, input logic [bsta_pkg::ADDR_W-1:0] id);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= bsta_pkg::PADDR_W'(slot * 8);
		pwdata <= {16'($urandom), id};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		id_mirror[slot] = id;
		@(negedge clk);
	endtask

	task automatic drain();
		while (pending_sightings.size() != 0)
			@(negedge clk);
	endtask

	task automatic check_result();
		sighting_t want;
		if (pending_sightings.size() == 0) begin
			report_mismatch("result with no request pending", 64'(visible_mask), 64'd0);
			return;
		end
		want = pending_sightings.pop_front();
		if (matched !== want.matched)
			report_mismatch("matched", 64'(matched), 64'(want.matched));
		if (match_index !== want.index)
			report_mismatch("match_index", 64'(match_index), 64'(want.index));
		if (entry_strength !== want.strength)
			report_mismatch("entry_strength", 64'(entry_strength), 64'(want.strength));
		if (entry_last_seen !== want.last_seen)
			report_mismatch("entry_last_seen", 64'(entry_last_seen), 64'(want.last_seen));
		if (visible_mask !== want.mask)
			report_mismatch("visible_mask", 64'(visible_mask), 64'(want.mask));
	endtask

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			check_result();

	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!squeeze_done && accepted_total >= SQUEEZE_AT) begin
				out_stall <= 1'b1;
				repeat (SQUEEZE_CYCLES)
					@(negedge clk);
				squeeze_done = 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 10))
					@(negedge clk);
			end else begin
				out_stall <= 1'b0;
				@(negedge clk);
			end
		end
	end

	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		func = bsta_pkg::FUNC_REPORT;
		beacon_address = '0;
		signal_strength = '0;
		now_ms = '0;
		entry_index = '0;
		for (int i = 0; i < bsta_pkg::NUM_ENTRIES; i++) begin
			id_mirror[i] = bsta_pkg::ID_RESET[i];
			strength_mirror[i] = '0;
			seen_mirror[i] = '0;
		end

		add_row(bsta_pkg::FUNC_READ, 0, 0, 0, 0, 1, 0, 0, 0, 0, 8'h00);
		add_row(bsta_pkg::FUNC_READ, ADDR_MAX, 8'h7F, TIME_MAX, 7, 1, 0, 0, 0, 0, 8'h00);
		add_row(bsta_pkg::FUNC_REPORT, bsta_pkg::ID_RESET[0], 8'h80, 5000, 7, 1,
			1, 0, 8'h80, 5000, 8'h01);
		add_row(bsta_pkg::FUNC_REPORT, bsta_pkg::ID_RESET[1], 8'h7F, 5100, 0, 1,
			0, 0, 0, 0, 8'h01);
		add_row(bsta_pkg::FUNC_REPORT, bsta_pkg::ID_RESET[1], 8'h00, 5100, 0, 1,
			0, 0, 0, 0, 8'h01);
		add_row(bsta_pkg::FUNC_REPORT, bsta_pkg::ID_RESET[7], 8'hFF, 5500, 0, 1,
			1, 7, 8'hFF, 5500, 8'h81);
		add_row(bsta_pkg::FUNC_REPORT, 0, 8'hFB, 5999, 0, 1, 0, 0, 0, 0, 8'h81);
		add_row(bsta_pkg::FUNC_REPORT, ADDR_MAX, 8'hFB, 6000, 0, 1, 0, 0, 0, 0, 8'h80);
		add_row(bsta_pkg::FUNC_READ, 0, 0, 0, 7, 1, 0, 0, 8'hFF, 5500, 8'h80);
		add_row(bsta_pkg::FUNC_READ, 0, 0, 0, 0, 1, 0, 0, 0, 0, 8'h80);
		add_row(bsta_pkg::FUNC_REPORT, bsta_pkg::ID_RESET[3], 8'hEC, 0, 0, 1,
			1, 3, 8'hEC, 0, 8'h08);
		add_row(bsta_pkg::FUNC_REPORT, bsta_pkg::ID_RESET[3], 8'hE2, TIME_MAX, 0, 1,
			1, 3, 8'hE2, TIME_MAX, 8'h08);
		add_row(bsta_pkg::FUNC_REPORT, bsta_pkg::ID_RESET[2], 8'hD8, 100, 0, 0,
			0, 0, 0, 0, 0);
		add_row(bsta_pkg::FUNC_REPORT, bsta_pkg::ID_RESET[6], 8'hCE, 1099, 5, 0,
			0, 0, 0, 0, 0);
		add_row(bsta_pkg::FUNC_REPORT, bsta_pkg::ID_RESET[5], 8'hFF, 1100, 2, 0,
			0, 0, 0, 0, 0);
		add_row(bsta_pkg::FUNC_READ, ADDR_MAX, 8'h80, TIME_MAX, 5, 0, 0, 0, 0, 0, 0);
		add_row(bsta_pkg::FUNC_REPORT, bsta_pkg::ID_RESET[4], 8'h01, 1100, 0, 0,
			0, 0, 0, 0, 0);
		add_row(bsta_pkg::FUNC_REPORT, bsta_pkg::ID_RESET[4], 8'h80, 1100, 0, 0,
			0, 0, 0, 0, 0);
		add_row(bsta_pkg::FUNC_READ, 0, 0, 0, 3, 0, 0, 0, 0, 0, 0);
		add_row(bsta_pkg::FUNC_READ, 0, 0, 0, 6, 0, 0, 0, 0, 0, 0);

		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[n])
			send_request(script[n].req, script[n].typed, script[n].want);
		in_valid <= 1'b0;
		drain();

		for (int phase = 1; phase <= 5; phase++) begin
			calm = (phase == 5);
			for (int i = 0; i < bsta_pkg::NUM_ENTRIES; i++) begin
				case (phase)
					1: write_beacon_id(i, rand48());
					2: write_beacon_id(i, '0);
					3: write_beacon_id(i, ADDR_MAX);
					4: write_beacon_id(i, (i > 0 && $urandom_range(0, 2) == 0) ?
						id_mirror[$urandom_range(0, i-1)] : rand48());
					default: write_beacon_id(i, bsta_pkg::ID_RESET[i]);
				endcase
			end
			psel <= 1'b0;
			penable <= 1'b0;
			pwrite <= 1'b0;
			@(negedge clk);
			clock_ms = rand48();
			repeat (PHASE_ITEMS)
				send_request(next_request(), 1'b0, '0);
			in_valid <= 1'b0;
			drain();
		end

		repeat (20)
			@(negedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
design/bsta_pkg.sv
design/bsta_cell.sv
design/beacon_strength_table_with_aging_core.sv
test/beacon_strength_table_with_aging_core_test.sv
